/* rtl/etcr_pkg.sv */
// Shared constants, types and the quarter-wave sine table function for the
// elevation color ramp. No dependencies; imported by every other file.
`timescale 1ns / 1ps

package etcr_pkg;

  // Elevation and clip values are signed Q16.16 words.
  localparam int ElevW     = 32;
  localparam int FracW     = 16;
  localparam int One       = 1 << FracW;
  localparam int TdataInW  = ((ElevW + 7) / 8) * 8;

  // Divider: the shifted quotient 3*(e-lo)/d + 3 lies in [0, 12) and carries
  // FracW fractional bits; the remainder stays below 16*d.
  localparam int QuoW      = FracW + 4;
  localparam int DivSteps  = QuoW;
  localparam int RemW      = ElevW + 4;

  // Phase u in units of pi, signed, within [-4, 8].
  localparam int UW        = FracW + 5;

  // Quarter-wave sine table.
  localparam int SineDepth = 256;
  localparam int SineIdxW  = $clog2(SineDepth + 1);
  localparam int SineValW  = FracW + 1;
  localparam int YW        = SineValW + 1;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // round(65536/pi) and the width of the y/pi product.
  localparam int InvPiQ16  = 20861;
  localparam int PW        = YW + FracW;

  // Channel values before byte conversion.
  localparam int ChanW     = UW + 1;
  localparam int ChanOutW  = 8;
  localparam int OutW      = 3 * ChanOutW;

  // Configuration register indexes and reset values.
  localparam int CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgClipLow  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgClipHigh = CfgIdxW'(1);
  localparam logic [ElevW-1:0]   ClipLowRst  = ElevW'(0);
  localparam logic [ElevW-1:0]   ClipHighRst = ElevW'(One);

  // Saturation flags that travel alongside the divider stages.
  typedef struct packed {
    logic sat_lo;
    logic sat_hi;
  } div_tag_t;

  // One entry of the table: round(65536*sin(pi/2*k/SineDepth)) from a
  // nine-term Taylor series in Q30 integer arithmetic.
  function automatic logic [SineValW-1:0] sine_entry(input int unsigned k);
    logic [63:0]        theta;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    theta = HalfPiQ30 * 64'(k) / 64'(SineDepth);
    term  = theta;
    sum   = $signed(theta);
    for (int n = 1; n <= 8; n++) begin
      term = (term * theta) >> 30;
      term = (term * theta) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 64'sd8192) >>> 14;
    if (v > One) begin
      v = One;
    end
    return v[SineValW-1:0];
  endfunction

endpackage

/* rtl/etcr_div.sv */
// Pipelined restoring divider, one quotient bit per stage, for the phase
// quotient of the color ramp. Depends on etcr_pkg.
`timescale 1ns / 1ps

module etcr_div import etcr_pkg::*; (
  input  logic                clk_i,
  input  logic [DivSteps-1:0] en_i,
  input  logic [RemW-1:0]     rem_i,
  input  logic [RemW-1:0]     d16_i,
  input  div_tag_t            tag_i,
  output logic [QuoW-1:0]     quo_o,
  output div_tag_t            tag_o
);

  logic [RemW-1:0] rem_q [DivSteps-1];
  logic [QuoW-1:0] quo_q [DivSteps];
  div_tag_t        tag_q [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [RemW-1:0] rem_in;
    logic [QuoW-1:0] quo_in;
    div_tag_t        tag_in;
    logic [RemW:0]   dbl;
    logic [RemW:0]   diff;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    // The remainder is doubled and the scaled divisor is taken off when it fits.
    assign dbl  = {rem_in, 1'b0};
    assign diff = dbl - {1'b0, d16_i};
    assign take = dbl >= {1'b0, d16_i};

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        quo_q[k] <= {quo_in[QuoW-2:0], take};
        tag_q[k] <= tag_in;
      end
    end

    if (k < DivSteps - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          rem_q[k] <= take ? diff[RemW-1:0] : dbl[RemW-1:0];
        end
      end
    end
  end

  assign quo_o = quo_q[DivSteps-1];
  assign tag_o = tag_q[DivSteps-1];

endmodule

/* rtl/elevation_to_color_ramp_unit.sv */
// Elevation to color ramp: maps one Q16.16 elevation sample to a 24-bit
// red/green/blue color. Depends on etcr_pkg and etcr_div.
//
// Usage. Samples arrive as beats on the slave stream: tdata carries the signed
// elevation, tuser the loose-mode flag. Each accepted beat yields exactly one
// beat on the master stream whose tdata holds red, green and blue bytes. The
// clip range is set through the configuration write channel (index 0 is the
// lower clip elevation, index 1 the upper one, other indexes are ignored);
// it should be written only while no sample is in flight, and it applies to
// samples accepted from the next cycle on. cfg_ready_o is always high.
//
// Timing. The datapath is a 31-stage pipeline: a result is presented on the
// master side once its input beat has passed through every stage. One beat
// is taken every cycle unless the slave side is stalled; the length is set by
// the 20-stage divider that forms the quotient one bit per stage.
// Reset empties the pipeline and returns the clip range to [0.0, 1.0].
// When the receiver stalls, the result is held in the output register and
// the stages behind it keep filling empty slots, so the slave side is only
// stalled once every stage holds a sample.
`timescale 1ns / 1ps

module elevation_to_color_ramp_unit import etcr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Sample stream.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [TdataInW-1:0] s_axis_tdata_i,   // [31:0] elevation
  input  logic [0:0]          s_axis_tuser_i,   // [0] loose_mode
  // Color stream.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutW-1:0]     m_axis_tdata_o,   // [7:0] red, [15:8] green, [23:16] blue
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [ElevW-1:0]    cfg_data_i
);

  // Stage map.
  localparam int StA    = 0;               // elevation minus clip_low
  localparam int StS    = 1;               // plus the range width
  localparam int StN    = 2;               // times three
  localparam int StC    = 3;               // saturation checks
  localparam int StDiv0 = 4;               // first divider stage
  localparam int StU    = StDiv0 + DivSteps; // phase u
  localparam int StF    = StU + 1;         // fold to a quarter wave
  localparam int StR    = StF + 1;         // table read
  localparam int StM    = StR + 1;         // y times 1/pi
  localparam int StYp   = StM + 1;         // rounded y/pi
  localparam int StCh   = StYp + 1;        // channel values
  localparam int StOut  = StCh + 1;        // output bytes
  localparam int NStg   = StOut + 1;

  localparam int AW  = ElevW + 1;
  localparam int SW  = ElevW + 2;
  localparam int NW  = RemW;
  localparam int IpW = FracW + SineIdxW + 1;

  localparam logic signed [UW-1:0] UMin = UW'(-4 * One);
  localparam logic signed [UW-1:0] UMax = UW'(8 * One);
  localparam int YpLimit = InvPiQ16;

  // ---------------------------------------------------------------------
  // Configuration registers and values derived from the clip range. d_q is
  // registered from them and dpos_q and d12_q from d_q, before any stage reads them.
  // ---------------------------------------------------------------------
  logic [ElevW-1:0]    clip_low_q;
  logic [ElevW-1:0]    clip_high_q;
  logic signed [AW-1:0] d_q;
  logic                dpos_q;
  logic [RemW-1:0]     d12_q;
  logic [RemW-1:0]     d16;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_low_q  <= ClipLowRst;
      clip_high_q <= ClipHighRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgClipLow:  clip_low_q  <= cfg_data_i;
        CfgClipHigh: clip_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= {clip_high_q[ElevW-1], clip_high_q} - {clip_low_q[ElevW-1], clip_low_q};
    dpos_q <= !d_q[AW-1] && (d_q != '0);
    d12_q  <= (RemW'(d_q[ElevW-1:0]) << 3) + (RemW'(d_q[ElevW-1:0]) << 2);
  end

  // A positive range width is below 2^ElevW, so its low bits shifted by four
  // give 16*d exactly.
  assign d16 = {d_q[ElevW-1:0], 4'b0000};

  // ---------------------------------------------------------------------
  // Pipeline control. A stage loads when the output is being taken or when it
  // or any stage after it up to the output is empty.
  // ---------------------------------------------------------------------
  logic [NStg-1:0] v_q;
  logic [NStg-1:0] v_in;
  logic [NStg-1:0] en;
  logic [StCh:0]   loose_q;
  logic [StCh:0]   loose_in;

  always_comb begin
    for (int k = 0; k < NStg; k++) begin
      en[k] = m_axis_tready_i || ((v_q | ((NStg'(1) << k) - NStg'(1))) != '1);
    end
  end

  assign s_axis_tready_o = en[StA];
  assign m_axis_tvalid_o = v_q[StOut];

  // What each stage takes in: the new beat for the first one, the stage in
  // front of it for the rest.
  assign v_in     = {v_q[NStg-2:0], s_axis_tvalid_i};
  assign loose_in = {loose_q[StCh-1:0], s_axis_tuser_i[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // The loose-mode flag rides along with the sample up to the channel stage.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= StCh; k++) begin
      if (en[k]) begin
        loose_q[k] <= loose_in[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Front end: numerator 3*(e - lo) + 3*d = 3*(e - lo + d), which moves the
  // quotient into [0, 12) so that the divider works on unsigned values.
  // ---------------------------------------------------------------------
  logic [ElevW-1:0]      elev;
  logic signed [AW-1:0]  a_q;
  logic signed [SW-1:0]  s_q;
  logic [NW-1:0]         np_q;
  logic [RemW-1:0]       rem0_q;
  div_tag_t              tag0_q;
  div_tag_t              tag_c;
  logic                  sat_lo_c;

  assign elev = s_axis_tdata_i[ElevW-1:0];

  always_ff @(posedge clk_i) begin
    if (en[StA]) begin
      a_q <= {elev[ElevW-1], elev} - {clip_low_q[ElevW-1], clip_low_q};
    end
    if (en[StS]) begin
      s_q <= {a_q[AW-1], a_q} + {d_q[AW-1], d_q};
    end
    if (en[StN]) begin
      np_q <= {{2{s_q[SW-1]}}, s_q} + {s_q[SW-1], s_q, 1'b0};
    end
  end

  // An empty or inverted range, or a sample below the ramp by more than
  // one span, pins the quotient to its low limit; two spans or more
  // above the ramp pins it to the high limit.
  assign sat_lo_c      = !dpos_q || np_q[NW-1];
  assign tag_c.sat_lo  = sat_lo_c;
  assign tag_c.sat_hi  = !sat_lo_c && (np_q >= d12_q);

  always_ff @(posedge clk_i) begin
    if (en[StC]) begin
      rem0_q <= np_q;
      tag0_q <= tag_c;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: Q = floor(np * 2^FracW / d), one bit per stage.
  // ---------------------------------------------------------------------
  logic [QuoW-1:0] quo;
  div_tag_t        tag_div;

  etcr_div u_div (
    .clk_i (clk_i),
    .en_i  (en[StDiv0 +: DivSteps]),
    .rem_i (rem0_q),
    .d16_i (d16),
    .tag_i (tag0_q),
    .quo_o (quo),
    .tag_o (tag_div)
  );

  // ---------------------------------------------------------------------
  // Phase u = Q - 4 in units of pi, then the sine from the table.
  // ---------------------------------------------------------------------
  logic signed [UW-1:0] u_d;
  logic signed [UW-1:0] u_q;

  always_comb begin
    if (tag_div.sat_lo) begin
      u_d = UMin;
    end else if (tag_div.sat_hi) begin
      u_d = UMax;
    end else begin
      u_d = UW'({1'b0, quo}) - UW'(4 * One);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StU]) begin
      u_q <= u_d;
    end
  end

  // Fold: u modulo 2 picks the sign from its unit bit, and the fraction is
  // mirrored about one half so that it indexes a quarter wave.
  logic [FracW-1:0]          r_raw;
  logic [FracW-1:0]          r_fold;
  logic [IpW-1:0]            ip;
  logic [IpW-FracW:0]        idx_full;
  logic [SineIdxW-1:0]       idx_d;
  logic [SineIdxW-1:0]       idx_q;
  logic                      neg_q;
  logic signed [UW-1:0]      u_f_q;

  assign r_raw    = u_q[FracW-1:0];
  assign r_fold   = (r_raw > FracW'(One / 2)) ? FracW'(0) - r_raw : r_raw;
  assign ip       = IpW'(r_fold) * IpW'(SineDepth) + IpW'(One / 4);
  assign idx_full = ip[IpW-1:FracW-1];
  assign idx_d    = (idx_full > (IpW - FracW + 1)'(SineDepth)) ?
                    SineIdxW'(SineDepth) : idx_full[SineIdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (en[StF]) begin
      idx_q <= idx_d;
      neg_q <= u_q[FracW];
      u_f_q <= u_q;
    end
  end

  // Quarter-wave table, folded to constants at elaboration.
  logic [SineValW-1:0] sine_rom [SineDepth+1];

  for (genvar k = 0; k <= SineDepth; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k);
  end

  logic signed [YW-1:0] y_q;
  logic signed [UW-1:0] u_r_q;
  logic [YW-1:0]        s_ext;

  assign s_ext = {1'b0, sine_rom[idx_q]};

  always_ff @(posedge clk_i) begin
    if (en[StR]) begin
      y_q   <= neg_q ? YW'(0) - s_ext : s_ext;
      u_r_q <= u_f_q;
    end
  end

  // ---------------------------------------------------------------------
  // y/pi = floor((y*20861 + 2^15) / 2^16), then the three channels.
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] p_q;
  logic signed [YW-1:0] y_m_q;
  logic signed [UW-1:0] u_m_q;

  always_ff @(posedge clk_i) begin
    if (en[StM]) begin
      p_q   <= PW'(y_q) * PW'(InvPiQ16);
      y_m_q <= y_q;
      u_m_q <= u_r_q;
    end
  end

  logic signed [PW-1:0] p_rnd;
  logic signed [YW-1:0] yp_q;
  logic signed [YW-1:0] y_y_q;
  logic signed [UW-1:0] u_y_q;

  assign p_rnd = p_q + PW'(One / 2);

  always_ff @(posedge clk_i) begin
    if (en[StYp]) begin
      yp_q  <= p_rnd[PW-1:FracW];
      y_y_q <= y_m_q;
      u_y_q <= u_m_q;
    end
  end

  // Red rises with the phase, blue falls with it, green follows the sine.
  logic signed [ChanW-1:0] red_q;
  logic signed [ChanW-1:0] green_q;
  logic signed [ChanW-1:0] blue_q;

  always_ff @(posedge clk_i) begin
    if (en[StCh]) begin
      red_q      <= ChanW'(u_y_q) - ChanW'(yp_q);
      green_q    <= ChanW'(y_y_q);
      blue_q     <= ChanW'(One) - ChanW'(u_y_q) - ChanW'(yp_q);
    end
  end

  // Loose mode maps the channel c to (c + 1)/2; then the value is taken
  // in units of 1/256 and clamped to a byte.
  function automatic logic [ChanOutW-1:0] to_byte(input logic signed [ChanW-1:0] c,
                                                  input logic loose);
    logic signed [ChanW-1:0] sh;
    logic signed [ChanW-1:0] cc;
    logic [ChanW-9:0]        b;
    sh = c + ChanW'(One);
    cc = loose ? {sh[ChanW-1], sh[ChanW-1:1]} : c;
    b  = cc[ChanW-1:8];
    if (b[ChanW-9]) begin
      return '0;
    end else if (|b[ChanW-10:ChanOutW]) begin
      return '1;
    end
    return b[ChanOutW-1:0];
  endfunction

  logic [OutW-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en[StOut]) begin
      out_q <= {to_byte(blue_q, loose_q[StCh]),
                to_byte(green_q, loose_q[StCh]),
                to_byte(red_q, loose_q[StCh])};
    end
  end

  assign m_axis_tdata_o = out_q;

`ifndef SYNTHESIS
  // The slave side only stalls when every stage is full and the output waits.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> ((&v_q) && !m_axis_tready_i))
    else $error("input stalled while the pipeline has room");

  // The saturated quotient keeps the phase within [-4, 8].
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[StU] |-> (u_q >= UMin && u_q <= UMax))
    else $error("phase out of range");

  // The folded index never runs past the last table entry.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[StF] |-> (idx_q <= SineIdxW'(SineDepth)))
    else $error("sine table index out of range");

  // y/pi stays within one over pi of full scale.
  a_ypi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[StYp] |-> (yp_q >= -YpLimit && yp_q <= YpLimit))
    else $error("y/pi out of range");
`endif

endmodule
